### src/dfm_pkg.sv
// Shared types and constants for the DLE framed message encoder.
// No dependencies.
package dfm_pkg;

  localparam int unsigned DFM_MAX_PAYLOAD = 223;
  localparam int unsigned DFM_FIFO_DEPTH  = 2;

  localparam logic [7:0] DLE_BYTE  = 8'h10;
  localparam logic [7:0] STX_BYTE  = 8'h02;
  localparam logic [7:0] ETX_BYTE  = 8'h03;
  localparam logic [7:0] MSG_TYPE  = 8'h93;
  localparam logic [7:0] HDR_EXTRA = 8'd11;

  // byte slots of one frame
  localparam logic [4:0] POS_DLE0 = 5'd0;
  localparam logic [4:0] POS_STX  = 5'd1;
  localparam logic [4:0] POS_TYPE = 5'd2;
  localparam logic [4:0] POS_LEN  = 5'd3;
  localparam logic [4:0] POS_PRIO = 5'd4;
  localparam logic [4:0] POS_PGN0 = 5'd5;
  localparam logic [4:0] POS_PGN1 = 5'd6;
  localparam logic [4:0] POS_PGN2 = 5'd7;
  localparam logic [4:0] POS_DST  = 5'd8;
  localparam logic [4:0] POS_SRC  = 5'd9;
  localparam logic [4:0] POS_TS0  = 5'd10;
  localparam logic [4:0] POS_TS1  = 5'd11;
  localparam logic [4:0] POS_TS2  = 5'd12;
  localparam logic [4:0] POS_TS3  = 5'd13;
  localparam logic [4:0] POS_CNT  = 5'd14;
  localparam logic [4:0] POS_PAY  = 5'd15;
  localparam logic [4:0] POS_CHK  = 5'd16;
  localparam logic [4:0] POS_DLE1 = 5'd17;
  localparam logic [4:0] POS_ETX  = 5'd18;

  typedef struct packed {
    logic        is_hdr;
    logic        last;
    logic        has_pay;
    logic [2:0]  priority_req;
    logic [17:0] pgn;
    logic [7:0]  destination;
    logic [7:0]  source;
    logic [31:0] timestamp;
    logic [7:0]  len;
    logic [7:0]  payload_byte;
  } dfm_desc_t;

endpackage

### src/dfm_fifo.sv
// Short request queue between the front and back parts.
// Depends on dfm_pkg (descriptor type).
module dfm_fifo #(
  parameter int unsigned DEPTH = dfm_pkg::DFM_FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dfm_pkg::dfm_desc_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output dfm_pkg::dfm_desc_t head_o,
  output logic              head_valid_o
);
  import dfm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dfm_desc_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FULL_CNT);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("queue underflow");

endmodule

### src/dfm_front.sv
// Front part: accepts input requests, tracks message position, builds descriptors.
// Depends on dfm_pkg.
module dfm_front #(
  parameter int unsigned MAX_PAYLOAD = dfm_pkg::DFM_MAX_PAYLOAD
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [87:0]        s_tdata_i,
  input  logic               full_i,
  output logic               push_o,
  output dfm_pkg::dfm_desc_t push_data_o
);
  import dfm_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [7:0] rem_q, rem_d;
  logic [7:0] len_in, len_sat;
  logic       first;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;
  assign len_in     = s_tdata_i[76:69];
  assign len_sat    = (len_in > MAX_LEN) ? MAX_LEN : len_in;
  assign first      = (rem_q == '0);

  always_comb begin
    push_data_o.is_hdr       = first;
    push_data_o.priority_req = s_tdata_i[2:0];
    push_data_o.pgn          = s_tdata_i[20:3];
    push_data_o.destination  = s_tdata_i[28:21];
    push_data_o.source       = s_tdata_i[36:29];
    push_data_o.timestamp    = s_tdata_i[68:37];
    push_data_o.len          = len_sat;
    push_data_o.payload_byte = s_tdata_i[84:77];
    if (first) begin
      push_data_o.has_pay = (len_sat != '0);
      push_data_o.last    = (len_sat <= 8'd1);
      rem_d = (len_sat == '0) ? '0 : len_sat - 8'd1;
    end else begin
      push_data_o.has_pay = 1'b1;
      push_data_o.last    = (rem_q == 8'd1);
      rem_d = rem_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (push_o) begin
      rem_q <= rem_d;
    end
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < MAX_LEN) else $error("payload count out of range");

endmodule

### src/dfm_back.sv
// Back part: serialises descriptors into the stuffed byte stream with checksum.
// Depends on dfm_pkg.
module dfm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfm_pkg::dfm_desc_t head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [7:0]         m_tdata_o,
  output logic               m_tlast_o,
  output logic               m_tuser_o
);
  import dfm_pkg::*;

  logic       busy_q, busy_d;
  logic       dup_q, dup_d;
  logic [4:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic       ovalid_q;
  logic [7:0] odata_q;
  logic       olast_q, ouser_q;

  logic [4:0] cur_pos;
  logic [7:0] cur_byte;
  logic       stuffed, hold, fire, done;

  assign cur_pos = busy_q ? pos_q : (head_i.is_hdr ? POS_DLE0 : POS_PAY);

  always_comb begin
    unique case (cur_pos)
      POS_DLE0: cur_byte = DLE_BYTE;
      POS_STX:  cur_byte = STX_BYTE;
      POS_TYPE: cur_byte = MSG_TYPE;
      POS_LEN:  cur_byte = head_i.len + HDR_EXTRA;
      POS_PRIO: cur_byte = {5'b0, head_i.priority_req};
      POS_PGN0: cur_byte = head_i.pgn[7:0];
      POS_PGN1: cur_byte = head_i.pgn[15:8];
      POS_PGN2: cur_byte = {6'b0, head_i.pgn[17:16]};
      POS_DST:  cur_byte = head_i.destination;
      POS_SRC:  cur_byte = head_i.source;
      POS_TS0:  cur_byte = head_i.timestamp[7:0];
      POS_TS1:  cur_byte = head_i.timestamp[15:8];
      POS_TS2:  cur_byte = head_i.timestamp[23:16];
      POS_TS3:  cur_byte = head_i.timestamp[31:24];
      POS_CNT:  cur_byte = head_i.len;
      POS_PAY:  cur_byte = head_i.payload_byte;
      POS_CHK:  cur_byte = 8'd0 - sum_q;
      POS_DLE1: cur_byte = DLE_BYTE;
      POS_ETX:  cur_byte = ETX_BYTE;
      default:  cur_byte = 8'h00;
    endcase
  end

  assign stuffed = (cur_pos >= POS_TYPE) && (cur_pos <= POS_CHK);
  assign hold    = stuffed && (cur_byte == DLE_BYTE) && !dup_q;
  assign fire    = head_valid_i && (!ovalid_q || m_tready_i);
  assign done    = (cur_pos == POS_ETX)
                || ((cur_pos == POS_PAY) && !head_i.last)
                || ((cur_pos == POS_CNT) && !head_i.has_pay && !head_i.last);
  assign pop_o   = fire && !hold && done;

  always_comb begin
    busy_d = busy_q;
    dup_d  = dup_q;
    pos_d  = pos_q;
    sum_d  = sum_q;
    if (fire) begin
      dup_d = hold;
      if (stuffed && !dup_q && (cur_pos <= POS_PAY)) begin
        sum_d = (cur_pos == POS_TYPE) ? cur_byte : sum_q + cur_byte;
      end
      if (hold) begin
        busy_d = 1'b1;
        pos_d  = cur_pos;
      end else if (done) begin
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        pos_d  = ((cur_pos == POS_CNT) && !head_i.has_pay) ? POS_CHK : cur_pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      dup_q    <= 1'b0;
      pos_q    <= POS_DLE0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      dup_q  <= dup_d;
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      if (fire) begin
        ovalid_q <= 1'b1;
      end else if (m_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      odata_q <= cur_byte;
      olast_q <= !hold && done;
      ouser_q <= (cur_pos == POS_ETX);
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = ouser_q;

  a_etx_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o == ETX_BYTE && m_tlast_o)
    else $error("frame end not on closing ETX");
  a_dup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_q |-> busy_q && head_valid_i) else $error("stuffing with no request");
  a_dup_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && dup_q |-> cur_byte == DLE_BYTE) else $error("stuffed byte not DLE");

endmodule

### src/dle_framed_message_encoder.sv
// Top level: DLE STX/ETX framer; one output byte per cycle while a request is queued and the output is accepted.
// An accepted item is written into the request queue, and its bytes leave through the output register.
// A message's first item gives 16 to 28 bytes, a payload item 1 to 6 bytes,
// one per cycle while the output is accepted, paced by the serialiser slot sequence.
// Input is taken back to back while the 2-entry request queue has room.
// Asynchronous active-low reset empties the queue and returns to message start.
module dle_framed_message_encoder #(
  parameter int unsigned MAX_PAYLOAD = dfm_pkg::DFM_MAX_PAYLOAD,
  parameter int unsigned FIFO_DEPTH  = dfm_pkg::DFM_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // priority_req[2:0], pgn[20:3], destination[28:21], source[36:29],
  // timestamp[68:37], payload_length[76:69], payload_byte[84:77]
  input  logic [87:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tlast_o,  // run_last
  output logic        m_axis_tuser_o   // frame_end
);
  import dfm_pkg::*;

  dfm_desc_t push_data, head;
  logic      push, full, pop, head_valid;

  dfm_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i,
    .rst_ni,
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dfm_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  dfm_back u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tlast_o    (m_axis_tlast_o),
    .m_tuser_o    (m_axis_tuser_o)
  );

endmodule
